>>> design/bdm_pkg.sv
// ----------------------------------------------------------------------------
// bdm_pkg
// Shared types, codes and defaults for the bracket depth matcher.
// ----------------------------------------------------------------------------
package bdm_pkg;

  // Default configuration
  localparam int unsigned DefStackDepth = 64;
  localparam int unsigned DefIndexBits  = 16;

  // Token kind codes on the input
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_OPEN  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  // Stack operation codes between front and back
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  // Input transaction
  typedef struct packed {
    logic       first_item;
    logic       removed;
    logic [1:0] kind;
    logic [1:0] pair_class;
  } bdm_in_t;

  // Result transaction
  typedef struct packed {
    logic [15:0] piece_index;
    logic [6:0]  depth;
    logic        match_valid;
    logic [15:0] match_index;
    logic        overflow;
  } bdm_out_t;

endpackage

>>> design/bdm_ram.sv
// ----------------------------------------------------------------------------
// bdm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdm_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bdm_front.sv
// ----------------------------------------------------------------------------
// bdm_front
// Numbers incoming pieces and classifies each into a stack operation.
// ----------------------------------------------------------------------------
module bdm_front #(
  parameter int unsigned INDEX_BITS = 16,
  localparam int unsigned OW        = INDEX_BITS + 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bdm_pkg::bdm_in_t in_data_i,
  output logic             op_valid_o,
  input  logic             op_ready_i,
  output logic [OW-1:0]    op_data_o
);
  import bdm_pkg::*;

  logic [INDEX_BITS-1:0] cnt_q, cnt_d;
  logic [INDEX_BITS-1:0] idx;
  logic [1:0]            op;
  logic                  accept;

  assign accept     = in_valid_i & op_ready_i;
  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i;

  // Piece index: first item restarts numbering at zero
  assign idx   = in_data_i.first_item ? '0 : cnt_q;
  assign cnt_d = idx + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  // Classify token into a stack operation
  always_comb begin
    op = OP_NONE;
    if (!in_data_i.removed) begin
      case (in_data_i.kind)
        KIND_OPEN:  op = OP_PUSH;
        KIND_CLOSE: op = OP_POP;
        default:    op = OP_NONE;
      endcase
    end
  end

  assign op_data_o = {in_data_i.first_item, op, in_data_i.pair_class, idx};

endmodule

>>> design/bdm_queue.sv
// ----------------------------------------------------------------------------
// bdm_queue
// Two-entry FIFO decoupling the classifier from the stack engine.
// ----------------------------------------------------------------------------
module bdm_queue #(
  parameter int unsigned WIDTH = 21
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       level_q, level_d;
  logic             push, pop;

  assign wr_ready_o = (level_q != 2'd2);
  assign rd_valid_o = (level_q != 2'd0);
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;
  assign rd_data_o  = slot_q[rd_ptr_q];

  always_comb begin
    level_d = level_q;
    case ({push, pop})
      2'b10:   level_d = level_q + 2'd1;
      2'b01:   level_d = level_q - 2'd1;
      default: level_d = level_q;
    endcase
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      level_q <= level_d;
    end
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> design/bdm_back.sv
// ----------------------------------------------------------------------------
// bdm_back
// Stack engine: top two entries in registers, the rest in RAM, with a
// prefetch of the third entry so a pop completes without waiting on a RAM read.
// ----------------------------------------------------------------------------
module bdm_back #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned INDEX_BITS  = 16,
  localparam int unsigned OW         = INDEX_BITS + 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  input  logic [OW-1:0]     op_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bdm_pkg::bdm_out_t out_data_o
);
  import bdm_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned EW = INDEX_BITS + 2;

  // Operation fields
  logic                  op_first;
  logic [1:0]            op_code;
  logic [1:0]            op_cls;
  logic [INDEX_BITS-1:0] op_idx;

  assign {op_first, op_code, op_cls, op_idx} = op_data_i;

  // Stack state
  logic [CW-1:0]         count_q, count_d, count_base;
  logic [INDEX_BITS-1:0] top_idx_q, top_idx_d, sec_idx_q, sec_idx_d;
  logic [1:0]            top_cls_q, top_cls_d, sec_cls_q, sec_cls_d;
  logic [EW-1:0]         rd_data;
  logic                  ram_we;
  logic                  take;

  // Output register
  logic     out_valid_q;
  bdm_out_t out_data_q, res;

  assign op_ready_o = ~out_valid_q | out_ready_i;
  assign take       = op_valid_i & op_ready_o;

  assign count_base = op_first ? '0 : count_q;

  // Stack update and result
  always_comb begin
    count_d   = count_base;
    top_idx_d = top_idx_q;
    top_cls_d = top_cls_q;
    sec_idx_d = sec_idx_q;
    sec_cls_d = sec_cls_q;
    ram_we    = 1'b0;

    res.piece_index = 16'(op_idx);
    res.depth       = 7'(count_base);
    res.match_valid = 1'b0;
    res.match_index = '0;
    res.overflow    = 1'b0;

    case (op_code)
      OP_PUSH: begin
        if (count_base == CW'(STACK_DEPTH)) begin
          res.overflow = 1'b1;
        end else begin
          ram_we    = 1'b1;
          sec_idx_d = top_idx_q;
          sec_cls_d = top_cls_q;
          top_idx_d = op_idx;
          top_cls_d = op_cls;
          count_d   = CW'(count_base + 1'b1);
        end
      end
      OP_POP: begin
        if ((count_base != '0) && (top_cls_q == op_cls)) begin
          res.match_valid = 1'b1;
          res.match_index = 16'(top_idx_q);
          top_idx_d       = sec_idx_q;
          top_cls_d       = sec_cls_q;
          {sec_idx_d, sec_cls_d} = rd_data;
          count_d         = CW'(count_base - 1'b1);
        end
        res.depth = 7'(count_d);
      end
      default: ;
    endcase

    // Hold everything when no operation is taken
    if (!take) begin
      count_d   = count_q;
      top_idx_d = top_idx_q;
      top_cls_d = top_cls_q;
      sec_idx_d = sec_idx_q;
      sec_cls_d = sec_cls_q;
      ram_we    = 1'b0;
    end
  end

  // Entry below the second is prefetched for the next pop
  bdm_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(count_base)),
    .wdata_i ({op_idx, op_cls}),
    .raddr_i (AW'(count_d - CW'(3))),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_idx_q <= top_idx_d;
    top_cls_q <= top_cls_d;
    sec_idx_q <= sec_idx_d;
    sec_cls_q <= sec_cls_d;
    if (take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> design/bracket_depth_matcher_unit.sv
// ----------------------------------------------------------------------------
// bracket_depth_matcher_unit
// Numbers token pieces and matches closing brackets against a stack of
// open brackets, reporting depth, matched opener index and overflow.
// ----------------------------------------------------------------------------
//   Channel  Signals                         Direction  Moves
//   in       in_valid_i/in_ready_o/in_data_i  input      one token piece
//   out      out_valid_o/out_ready_i/out_data_o output   one result per piece
//
// One transaction per cycle sustained while out_ready_i stays high; a piece is
// registered in the two-entry queue after the classifier, then by the stack
// engine into the output register. A pop needs no wait for a RAM read: the top
// two entries sit in registers and a one-read-port RAM prefetches the third entry.
// Reset clears the piece counter, stack count, queue and output valid; the
// stack RAM is not cleared. Output stalls fill the queue, then drop in_ready_o.
// ----------------------------------------------------------------------------
module bracket_depth_matcher_unit #(
  parameter int unsigned STACK_DEPTH = bdm_pkg::DefStackDepth,
  parameter int unsigned INDEX_BITS  = bdm_pkg::DefIndexBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bdm_pkg::bdm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bdm_pkg::bdm_out_t out_data_o
);
  import bdm_pkg::*;

  localparam int unsigned OW = INDEX_BITS + 5;

  logic          fq_valid, fq_ready;
  logic [OW-1:0] fq_data;
  logic          qb_valid, qb_ready;
  logic [OW-1:0] qb_data;

  // Front: numbering and classification
  bdm_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .op_valid_o (fq_valid),
    .op_ready_i (fq_ready),
    .op_data_o  (fq_data)
  );

  // Decoupling queue
  bdm_queue #(
    .WIDTH (OW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_data),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (qb_data)
  );

  // Back: stack engine and output register
  bdm_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (qb_valid),
    .op_ready_o  (qb_ready),
    .op_data_i   (qb_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A match and an overflow never come from the same piece
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.match_valid && out_data_o.overflow))
    else $error("match and overflow reported together");

  // Unmatched results carry a zero match index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.match_valid) |-> (out_data_o.match_index == '0))
    else $error("match index nonzero without a match");

  // Overflow only when the stack is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.overflow) |-> (out_data_o.depth == 7'(STACK_DEPTH)))
    else $error("overflow with stack not full");

endmodule
